// ===== src/bgq_pkg.sv =====
// Shared constants and operation codes for the bar grid quantizer.
package bgq_pkg;

    // Default table depth and tick resolution.
    localparam int TABLE_DEPTH_DEF    = 16;
    localparam int TICKS_PER_BEAT_DEF = 960;

    // A whole note holds four quarter beats.
    localparam int BEATS_PER_WHOLE = 4;

    // Width of the signed working value used to form the final bar line.
    localparam int RES_W = 35;

    // Operation codes carried by the opcode field of an input word.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FLOOR = 2'd1;
    localparam logic [1:0] OP_CEIL  = 2'd2;

endpackage

// ===== src/bgq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bgq_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
module bgq_div #(
    parameter int NW = 46,
    parameter int DW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quot,
    output logic [DW-1:0] o_rem
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;

    logic [DW:0]   shifted;
    logic [DW:0]   trial;
    logic          fits;
    logic [DW-1:0] n_rem;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        shifted = {r_rem, r_quo[NW-1]};
        trial   = shifted - {1'b0, r_dvs};
        fits    = (shifted >= {1'b0, r_dvs});
        n_rem   = fits ? trial[DW-1:0] : shifted[DW-1:0];
    end

    // Control: busy flag, step count and the done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient shifts in from the right as the dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== src/bar_grid_quantizer.sv =====
// Top level of the bar grid quantizer: command sequencer, table walk and result stage.
//
// The block snaps a tick position to the bar grid of a time-signature table held in
// one RAM of TABLE_DEPTH entries (start bar and precomputed bar length). A word is
// taken when start is high and busy is low; busy stays high until the word is done.
// A load keeps busy high while the bar length num * 4 * TICKS_PER_BEAT / den is formed
// by the bit-serial divider (46 bits wide with the default parameters); the entry is
// written when the divider is done. A floor or ceil query walks the entries in use
// (the configured count, capped at TABLE_DEPTH): each entry costs a RAM read, a
// multiply and an add/compare, and the closing remainder is again one divider bit per cycle.
// A query at or below zero skips the divider. Each result is shown for exactly one
// cycle with o_strobe high and is never held back, so the receiver must take it in
// that cycle; busy is already low in that cycle so the next word may be issued at
// once. The table has no reset; entries in use must be loaded before they are queried.
module bar_grid_quantizer #(
    parameter int TABLE_DEPTH    = bgq_pkg::TABLE_DEPTH_DEF,
    parameter int TICKS_PER_BEAT = bgq_pkg::TICKS_PER_BEAT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic [3:0]         i_entry_index,
    input  logic [15:0]        i_entry_bar,
    input  logic [7:0]         i_entry_num,
    input  logic [7:0]         i_entry_den,
    input  logic signed [31:0] i_position_ticks,
    output logic               o_strobe,
    output logic [31:0]        o_result_ticks,
    output logic [19:0]        o_bar_length_ticks,
    output logic               o_saturated
);

    localparam int WHOLE = bgq_pkg::BEATS_PER_WHOLE * TICKS_PER_BEAT;
    localparam int LW    = $clog2(255 * WHOLE + 1);
    localparam int PW    = LW + 18;
    localparam int SW    = LW + 26;
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MW    = 16 + LW;
    localparam int RW    = bgq_pkg::RES_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_WRD  = 3'd2;
    localparam logic [2:0] ST_WMUL = 3'd3;
    localparam logic [2:0] ST_WADD = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;
    localparam logic [2:0] ST_QDIV = 3'd6;

    // Control registers.
    logic [2:0] r_state, n_state;
    logic [4:0] r_entries;
    logic       r_strobe, n_strobe;

    // Word and walk registers.
    logic [1:0]           r_op;
    logic [AW-1:0]        r_waddr;
    logic [15:0]          r_bar_in;
    logic [7:0]           r_num;
    logic [7:0]           r_den;
    logic signed [SW-1:0] r_pos;
    logic [4:0]           r_idx;
    logic [4:0]           r_cnt;
    logic signed [SW-1:0] r_start;
    logic [15:0]          r_bar;
    logic [LW-1:0]        r_len;
    logic signed [PW-1:0] r_prod;
    logic [15:0]          r_ebar;
    logic [LW-1:0]        r_elen;

    // Result registers.
    logic [31:0] r_res;
    logic [19:0] r_blen;
    logic        r_sat;

    // RAM and divider hookup.
    logic          ram_we;
    logic [MW-1:0] ram_wdata;
    logic [MW-1:0] ram_rdata;
    logic [15:0]   ram_bar;
    logic [LW-1:0] ram_len;

    logic          div_start;
    logic [SW-1:0] div_dividend;
    logic [LW-1:0] div_divisor;
    logic          div_done;
    logic [SW-1:0] div_quot;
    logic [LW-1:0] div_rem;

    // Intermediate values.
    logic                 idx_ok;
    logic [4:0]           cnt_lim;
    logic [LW-1:0]        load_prod;
    logic [LW-1:0]        blen_load;
    logic signed [16:0]   bar_diff;
    logic signed [SW-1:0] estart;
    logic signed [SW-1:0] diff;
    logic [SW-1:0]        diff_u;
    logic signed [RW-1:0] res_pos, res_rem, res_len, res_val;
    logic [31:0]          res_out;
    logic                 res_big;

    bgq_ram #(
        .WIDTH (MW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(r_idx)),
        .o_rdata (ram_rdata)
    );

    bgq_div #(
        .NW (SW),
        .DW (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Decode of the input word and of the RAM entry being walked.
    always_comb begin
        idx_ok    = (32'(i_entry_index) < 32'(TABLE_DEPTH));
        cnt_lim   = (32'(r_entries) > 32'(TABLE_DEPTH)) ? 5'(TABLE_DEPTH) : r_entries;
        load_prod = LW'(i_entry_num) * LW'(WHOLE);
        ram_bar   = ram_rdata[MW-1:LW];
        ram_len   = ram_rdata[LW-1:0];
        bar_diff  = $signed({1'b0, ram_bar}) - $signed({1'b0, r_bar});
        estart    = r_start + SW'(r_prod);
        diff      = r_pos - r_start;
        diff_u    = diff[SW-1] ? '0 : diff;
    end

    // Bar length of a loaded entry, with the 4/4 fallback and a floor of one tick.
    always_comb begin
        if (r_num == 8'd0 || r_den == 8'd0) begin
            blen_load = LW'(WHOLE);
        end else if (div_quot[LW-1:0] == '0) begin
            blen_load = LW'(1);
        end else begin
            blen_load = div_quot[LW-1:0];
        end
        ram_wdata = {r_bar_in, blen_load};
    end

    // Final bar line from the remainder: floor drops it, ceil adds the rest of a bar.
    always_comb begin
        res_pos = RW'(r_pos);
        res_rem = $signed({{(RW - LW){1'b0}}, div_rem});
        res_len = $signed({{(RW - LW){1'b0}}, r_len});
        res_val = res_pos - res_rem;
        if (r_op == bgq_pkg::OP_CEIL && div_rem != '0) begin
            res_val = res_val + res_len;
        end
        res_big = (res_val > $signed({{(RW - 32){1'b0}}, 32'hFFFF_FFFF}));
        if (res_val[RW-1]) begin
            res_out = '0;
        end else if (res_big) begin
            res_out = '1;
        end else begin
            res_out = res_val[31:0];
        end
    end

    // Sequencer: next state, divider launches and table writes.
    always_comb begin
        n_state      = r_state;
        n_strobe     = 1'b0;
        ram_we       = 1'b0;
        div_start    = 1'b0;
        div_dividend = SW'(load_prod);
        div_divisor  = LW'(i_entry_den);
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_opcode)
                        bgq_pkg::OP_LOAD: begin
                            if (idx_ok) begin
                                div_start = 1'b1;
                                n_state   = ST_LOAD;
                            end
                        end
                        bgq_pkg::OP_FLOOR, bgq_pkg::OP_CEIL: begin
                            n_state = ST_WRD;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                if (div_done) begin
                    ram_we  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_WRD: begin
                n_state = (r_idx < r_cnt) ? ST_WMUL : ST_FIN;
            end
            ST_WMUL: begin
                n_state = ST_WADD;
            end
            ST_WADD: begin
                n_state = (estart > r_pos) ? ST_FIN : ST_WRD;
            end
            ST_FIN: begin
                if (r_pos <= 0) begin
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = diff_u;
                    div_divisor  = r_len;
                    n_state      = ST_QDIV;
                end
            end
            ST_QDIV: begin
                if (div_done) begin
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and the configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_strobe  <= 1'b0;
            r_entries <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_entries <= i_cfg_wdata;
            end
        end
    end

    // Word capture, table walk and result capture.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_op     <= i_opcode;
                    r_waddr  <= AW'(i_entry_index);
                    r_bar_in <= i_entry_bar;
                    r_num    <= i_entry_num;
                    r_den    <= i_entry_den;
                    r_pos    <= SW'(i_position_ticks);
                    r_idx    <= '0;
                    r_cnt    <= cnt_lim;
                    r_start  <= '0;
                    r_bar    <= '0;
                    r_len    <= LW'(WHOLE);
                end
            end
            ST_WMUL: begin
                // The next entry starts after whole bars of the current segment.
                r_prod <= bar_diff * $signed({1'b0, r_len});
                r_ebar <= ram_bar;
                r_elen <= ram_len;
            end
            ST_WADD: begin
                if (!(estart > r_pos)) begin
                    r_start <= estart;
                    r_bar   <= r_ebar;
                    r_len   <= r_elen;
                    r_idx   <= r_idx + 5'd1;
                end
            end
            ST_FIN: begin
                if (r_pos <= 0) begin
                    r_res  <= '0;
                    r_sat  <= 1'b0;
                    r_blen <= 20'(r_len);
                end
            end
            ST_QDIV: begin
                if (div_done) begin
                    r_res  <= res_out;
                    r_sat  <= res_big && !res_val[RW-1];
                    r_blen <= 20'(r_len);
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign busy               = (r_state != ST_IDLE);
    assign o_strobe           = r_strobe;
    assign o_result_ticks     = r_res;
    assign o_bar_length_ticks = r_blen;
    assign o_saturated        = r_sat;

endmodule

// ===== src/bgq_checker.sv =====
// Port-level checks for the bar grid quantizer, bound to the top level.
module bgq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_opcode,
    input logic        o_strobe,
    input logic [31:0] o_result_ticks,
    input logic [19:0] o_bar_length_ticks,
    input logic        o_saturated
);

    // A clamped result always reads as the largest tick value.
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_saturated) |-> (o_result_ticks == 32'hFFFF_FFFF))
        else $error("saturated result is not the maximum tick value");

    // Every bar has a length of at least one tick.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_bar_length_ticks != 20'd0))
        else $error("result word with a zero bar length");

    // Every word passes through further states before its result, so strobes never come back to back.
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two result words in consecutive cycles");

    // Nothing is in flight when a word is taken, so no result can follow at once.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result word one cycle after a word was taken");

    // A load word never produces a result; the property checks this at a single sample after the word is taken.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == bgq_pkg::OP_LOAD) |=> ##1 !o_strobe)
        else $error("result word after a table load");

endmodule

bind bar_grid_quantizer bgq_checker u_bgq_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .i_opcode           (i_opcode),
    .o_strobe           (o_strobe),
    .o_result_ticks     (o_result_ticks),
    .o_bar_length_ticks (o_bar_length_ticks),
    .o_saturated        (o_saturated)
);
